// ----- rtl/swsu_pkg.sv -----
// Shared types, constants and helpers for the square-wave sound unit.
// No dependencies.
`default_nettype none
package swsu_pkg;
   localparam int REGISTER_BYTES = 48;
   localparam int FRAME_DIVIDER  = 2048;
   localparam logic [15:0] WIN_BASE     = 16'hFF10;
   localparam logic [5:0]  MASTER_IDX   = 6'h16;
   localparam logic [15:0] CPS_RESET    = 16'd6087;
   localparam logic [16:0] CPS_MIN      = 17'd2048;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic access;     // perform read/write
      logic tick_pre;   // frame sequencer, length, envelope, timer subtract
      logic tick_iter;  // one timer reload step per channel
      logic tick_lvl;   // compute levels, add phase
      logic emit;       // present a sample and subtract phase
      logic rsp_load;   // load response register
      logic rsp_last;
      logic rsp_sample;
   } cmd_type;

   typedef struct packed {
      logic timers_done;  // no channel needs a reload
      logic phase_ge;     // phase at or above period
      logic phase_ge2;    // phase at or above twice the period
   } sts_type;

   function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] pos);
      logic [7:0] t;
      begin
         unique case (duty)
            2'd0: t = 8'h01;
            2'd1: t = 8'h81;
            2'd2: t = 8'h87;
            default: t = 8'h7E;
         endcase
         duty_bit = t[pos];
      end
   endfunction
endpackage
`default_nettype wire

// ----- rtl/square_wave_sound_unit.sv -----
// Top level of the square-wave sound unit.
// Depends on swsu_pkg, swsu_control, swsu_datapath.
`default_nettype none
// Reads, writes and unknown modes give one response in the cycle after
// acceptance; the next transaction is taken once that response has gone.
// A tick runs the frame sequencer and timer subtract on acceptance, then
// one timer reload step per channel until a step sees that none is left
// (both channels reload in parallel, so the larger count sets the length:
// up to eight reloads at the shortest period), then levels and phase. Up to
// four samples follow, one per cycle as the output drains, or one empty
// response when no sample is due; the last response of each item carries
// tlast. Config writes only while idle.
module square_wave_sound_unit #(
   parameter int FRAME_DIVIDER = swsu_pkg::FRAME_DIVIDER
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // bus_address, write_data, tick_cycles, pad
   input  wire logic [1:0]  req_tuser,  // mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // read_data, sample_value
   output logic             rsp_tuser,  // sample_valid
   output logic             rsp_tlast   // last_result
);
   swsu_pkg::cmd_type cmd;
   swsu_pkg::sts_type sts;
   logic rv, sv, lr, take;
   logic [7:0] rd;
   logic signed [15:0] smp;

   assign take = rv && rsp_tready;

   swsu_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .mode(req_tuser),
      .sts, .rsp_valid(rv), .rsp_take(take), .cmd
   );

   swsu_datapath #(.FRAME_DIVIDER(FRAME_DIVIDER)) u_dp (
      .clock, .reset, .csr_we, .csr_wdata,
      .mode(req_tuser), .bus_address(req_tdata[15:0]),
      .write_data(req_tdata[23:16]), .tick_cycles(req_tdata[29:24]),
      .cmd, .sts, .rsp_take(take), .rsp_valid(rv),
      .read_data(rd), .sample_valid(sv), .sample_value(smp), .last_result(lr)
   );

   assign rsp_tvalid = rv;
   assign rsp_tdata  = {smp, rd};
   assign rsp_tuser  = sv;
   assign rsp_tlast  = lr;
endmodule
`default_nettype wire

// ----- rtl/swsu_datapath.sv -----
// Datapath: register file, channel state, frame sequencer, sample phase.
// Depends on swsu_pkg.
`default_nettype none
module swsu_datapath #(
   parameter int FRAME_DIVIDER = swsu_pkg::FRAME_DIVIDER
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_we,
   input  wire logic [15:0]    csr_wdata,
   input  wire logic [1:0]     mode,
   input  wire logic [15:0]    bus_address,
   input  wire logic [7:0]     write_data,
   input  wire logic [5:0]     tick_cycles,
   input  wire swsu_pkg::cmd_type cmd,
   output swsu_pkg::sts_type   sts,
   input  wire logic           rsp_take,
   output logic                rsp_valid,
   output logic [7:0]          read_data,
   output logic                sample_valid,
   output logic signed [15:0]  sample_value,
   output logic                last_result
);
   localparam int FW = $clog2(FRAME_DIVIDER) + 1;

   logic [7:0]  regs_ff [swsu_pkg::REGISTER_BYTES];
   logic [swsu_pkg::REGISTER_BYTES-1:0] blank_ff;   // entry reads as zero
   logic [7:0]  master_ff;
   logic [7:0]  ctl_ff  [2][5];
   logic [15:0] cps_ff;
   logic [FW-1:0] frame_ff;
   logic [2:0]  step_ff;
   logic [16:0] phase_ff;
   logic [1:0]  en_ff;
   logic [3:0]  vol_ff [2];
   logic [2:0]  env_ff [2];
   logic signed [15:0] tmr_ff [2];
   logic [2:0]  dpos_ff [2];
   logic [6:0]  len_ff [2];
   logic [3:0]  lvl_ff [2];
   logic        rv_ff, sv_ff, last_ff;
   logic [7:0]  rd_ff;
   logic signed [15:0] smp_ff;
   logic [5:0]  cyc_ff;

   logic        in_win;
   logic        wr_acc;
   logic        arr_we;
   logic [15:0] offs;
   logic [5:0]  idx;
   logic [5:0]  cyc;
   logic [16:0] cps;
   logic [FW-1:0] fsum;
   logic        fstep;
   logic [3:0]  nstep;
   logic signed [15:0] per [2];
   logic signed [17:0] mixs;
   logic signed [15:0] mixc;

   assign offs   = bus_address - swsu_pkg::WIN_BASE;
   assign in_win = (bus_address >= swsu_pkg::WIN_BASE) && (offs < 16'(swsu_pkg::REGISTER_BYTES));
   assign idx    = offs[5:0];
   assign wr_acc = cmd.access && mode == swsu_pkg::MODE_WRITE && in_win;
   assign arr_we = wr_acc && idx != swsu_pkg::MASTER_IDX && !reset;
   assign cyc    = (tick_cycles > 6'd32) ? 6'd32 : tick_cycles;
   assign cps    = ({1'b0, cps_ff} < swsu_pkg::CPS_MIN) ? swsu_pkg::CPS_MIN : {1'b0, cps_ff};
   assign fsum   = frame_ff + FW'(cyc);
   assign fstep  = fsum >= FW'(FRAME_DIVIDER);
   assign nstep  = {1'b0, step_ff} + 4'd1;

   always_comb begin
      for (int c = 0; c < 2; c++)
         per[c] = 16'((13'd2048 - {2'b0, ctl_ff[c][4][2:0], ctl_ff[c][3]}) * 4);
   end

   // mixer
   always_comb begin
      mixs = '0;
      for (int c = 0; c < 2; c++)
         if (en_ff[c] && lvl_ff[c] != 4'd0)
            mixs = mixs + 18'(signed'({1'b0, lvl_ff[c]}) * 2000) - 18'sd15000;
      if (mixs > 18'sd32767) mixc = 16'sd32767;
      else if (mixs < -18'sd32768) mixc = -16'sd32768;
      else mixc = mixs[15:0];
   end

   assign sts.timers_done = !((en_ff[0] && tmr_ff[0] <= 0) || (en_ff[1] && tmr_ff[1] <= 0));
   assign sts.phase_ge    = phase_ff >= cps;
   assign sts.phase_ge2   = {1'b0, phase_ff} >= {cps, 1'b0};

   // register byte store, one write port
   always_ff @(posedge clock) begin
      if (arr_we) regs_ff[idx] <= write_data;
   end

   // state update
   always_ff @(posedge clock) begin
      if (cmd.tick_pre) cyc_ff <= cyc;
      if (reset) begin
         blank_ff  <= '1;
         master_ff <= 8'hF1;
         for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 5; k++) ctl_ff[c][k] <= 8'h00;
            vol_ff[c] <= '0; env_ff[c] <= '0; tmr_ff[c] <= '0;
            dpos_ff[c] <= '0; len_ff[c] <= '0; lvl_ff[c] <= '0;
         end
         cps_ff <= swsu_pkg::CPS_RESET;
         frame_ff <= '0; step_ff <= '0; phase_ff <= '0; en_ff <= '0;
      end else begin
         if (csr_we) cps_ff <= csr_wdata;
         // register access
         if (wr_acc) begin
            if (idx == swsu_pkg::MASTER_IDX) begin
               // master off clears the lower 32 bytes, master included
               if (!write_data[7]) begin
                  master_ff <= 8'h00;
                  blank_ff[31:0] <= '1;
                  en_ff <= '0;
               end else master_ff <= write_data;
            end else begin
               blank_ff[idx] <= 1'b0;
               if (master_ff[7] && (idx <= 6'h04 || (idx >= 6'h06 && idx <= 6'h09))) begin
                  automatic int c = (idx <= 6'h04) ? 0 : 1;
                  automatic logic [2:0] k = (idx <= 6'h04) ? idx[2:0] : 3'(idx - 6'h05);
                  ctl_ff[c][k] <= write_data;
                  if (k == 3'd1) len_ff[c] <= 7'd64 - {1'b0, write_data[5:0]};
                  if (k == 3'd4 && write_data[7]) begin
                     automatic logic signed [15:0] p =
                        16'((13'd2048 - {2'b0, write_data[2:0], ctl_ff[c][3]}) * 4);
                     en_ff[c]  <= 1'b1;
                     vol_ff[c] <= ctl_ff[c][2][7:4];
                     env_ff[c] <= ctl_ff[c][2][2:0];
                     tmr_ff[c] <= p;
                     if (len_ff[c] == 7'd0) len_ff[c] <= 7'd64;
                  end
               end
            end
         end
         // frame sequencer and timer subtract
         if (cmd.tick_pre) begin
            automatic logic [1:0] en_n = en_ff;
            frame_ff <= fstep ? fsum - FW'(FRAME_DIVIDER) : fsum;
            if (fstep) begin
               step_ff <= (nstep >= 4'd8) ? 3'd0 : nstep[2:0];
               for (int c = 0; c < 2; c++) begin
                  if (!nstep[0] && ctl_ff[c][4][6] && len_ff[c] != 0) begin
                     len_ff[c] <= len_ff[c] - 7'd1;
                     if (len_ff[c] == 7'd1) en_n[c] = 1'b0;
                  end
                  if (nstep == 4'd7 && en_n[c] && ctl_ff[c][2][2:0] != 0 && env_ff[c] != 0) begin
                     if (env_ff[c] == 3'd1) begin
                        env_ff[c] <= ctl_ff[c][2][2:0];
                        if (ctl_ff[c][2][3]) begin
                           if (vol_ff[c] != 4'd15) vol_ff[c] <= vol_ff[c] + 4'd1;
                        end else if (vol_ff[c] != 4'd0) vol_ff[c] <= vol_ff[c] - 4'd1;
                     end else env_ff[c] <= env_ff[c] - 3'd1;
                  end
               end
            end
            en_ff <= en_n;
            for (int c = 0; c < 2; c++)
               if (en_n[c]) tmr_ff[c] <= tmr_ff[c] - 16'(cyc);
         end
         // one reload per cycle per channel
         if (cmd.tick_iter) begin
            for (int c = 0; c < 2; c++)
               if (en_ff[c] && tmr_ff[c] <= 0) begin
                  tmr_ff[c]  <= tmr_ff[c] + per[c];
                  dpos_ff[c] <= dpos_ff[c] + 3'd1;
               end
         end
         if (cmd.tick_lvl) begin
            for (int c = 0; c < 2; c++)
               if (en_ff[c])
                  lvl_ff[c] <= swsu_pkg::duty_bit(ctl_ff[c][1][7:6], dpos_ff[c]) ?
                               vol_ff[c] : 4'd0;
            phase_ff <= phase_ff + {3'b0, cyc_ff, 8'h00};
         end
         if (cmd.emit) phase_ff <= phase_ff - cps;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (cmd.rsp_load) rv_ff <= 1'b1;
      else if (rsp_take) rv_ff <= 1'b0;
      if (cmd.rsp_load) begin
         last_ff <= cmd.rsp_last;
         sv_ff   <= cmd.rsp_sample;
         smp_ff  <= cmd.rsp_sample ? mixc : 16'sd0;
         if (!(cmd.access && mode == swsu_pkg::MODE_READ)) rd_ff <= 8'h00;
         else if (!in_win) rd_ff <= 8'hFF;
         else if (idx == swsu_pkg::MASTER_IDX)
            rd_ff <= {master_ff[7:4], 2'b00, en_ff[1], en_ff[0]};
         else if (blank_ff[idx]) rd_ff <= 8'h00;
         else rd_ff <= regs_ff[idx];
      end
   end

   assign rsp_valid    = rv_ff;
   assign read_data    = rd_ff;
   assign sample_valid = sv_ff;
   assign sample_value = smp_ff;
   assign last_result  = last_ff;
endmodule
`default_nettype wire

// ----- rtl/swsu_control.sv -----
// Controller FSM sequencing accesses, tick steps and sample emission.
// Depends on swsu_pkg.
`default_nettype none
module swsu_control (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  mode,
   input  wire swsu_pkg::sts_type sts,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_take,
   output swsu_pkg::cmd_type cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ITER = 3'd1;
   localparam logic [2:0] S_LVL  = 3'd2;
   localparam logic [2:0] S_EMIT = 3'd3;

   logic [2:0] state_ff, state_in;
   logic [2:0] count_ff, count_in;
   logic       slot;

   // response slot free now or freed this cycle
   assign slot = !rsp_valid || rsp_take;
   assign req_tready = (state_ff == S_IDLE) && slot;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid && slot) begin
            if (mode == swsu_pkg::MODE_TICK) begin
               cmd.tick_pre = 1'b1;
               state_in = S_ITER;
            end else begin
               cmd.access = 1'b1;
               cmd.rsp_load = 1'b1;
               cmd.rsp_last = 1'b1;
            end
         end
         S_ITER: if (sts.timers_done) state_in = S_LVL;
                 else cmd.tick_iter = 1'b1;
         S_LVL: begin
            cmd.tick_lvl = 1'b1;
            count_in = 3'd0;
            state_in = S_EMIT;
         end
         S_EMIT: if (slot) begin
            cmd.rsp_load = 1'b1;
            if (sts.phase_ge) begin
               // a sample is last when the fourth or when no further one is due
               cmd.emit = 1'b1;
               cmd.rsp_sample = 1'b1;
               count_in = count_ff + 3'd1;
               if (count_ff == 3'd3 || !sts.phase_ge2) begin
                  cmd.rsp_last = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               // no sample due: one empty terminating response
               cmd.rsp_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// ----- tb/tb_square_wave_sound_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for square_wave_sound_unit: register reads and
// writes and time ticks are predicted in SystemVerilog. Depends on swsu_pkg.
module tb_square_wave_sound_unit;

   localparam logic [1:0] MODE_NONE = 2'd3;   // undefined mode
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [5:0]  cyc;
   } bus_item_type;

   typedef struct {
      logic [7:0]         rd;
      logic               sv;
      logic signed [15:0] smp;
      logic               last;
   } sound_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // bus_address, write_data, tick_cycles, pad
   logic [1:0]  req_tuser = '0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // read_data, sample_value
   logic        rsp_tuser;        // sample_valid
   logic        rsp_tlast;        // last_result

   square_wave_sound_unit uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   bus_item_type     pending_items[$];
   sound_result_type expected_sound[$];
   bus_item_type     offered;
   int  n_offered = 0, n_taken = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0;
   bit  hold_req = 0, hold_done = 0;
   int  hold_cnt = 0;
   int  errors = 0;
   int  quiet_cycles = 0;

   // predictor state
   logic [7:0] regs [swsu_pkg::REGISTER_BYTES];
   logic [7:0] ctl_b [10];
   int  frame_cnt, frame_step, phase_acc, cps_reg;
   bit  ch_en [2];
   int  vol [2], env_cnt [2], ftimer [2], duty_step [2], len_cnt [2], level [2];

   function automatic int reload_period(int c);
      int f;
      f = ctl_b[c*5+3] | ((ctl_b[c*5+4] & 7) << 8);
      return (2048 - f) * 4;
   endfunction

   function automatic void retrigger(int c);
      ch_en[c] = 1;
      vol[c] = ctl_b[c*5+2] >> 4;
      env_cnt[c] = ctl_b[c*5+2] & 7;
      ftimer[c] = reload_period(c);
      if (len_cnt[c] == 0) len_cnt[c] = 64;
   endfunction

   function automatic void bus_write(int addr, logic [7:0] v);
      int i, c, k;
      if (addr < swsu_pkg::WIN_BASE || addr >= swsu_pkg::WIN_BASE + swsu_pkg::REGISTER_BYTES)
         return;
      i = addr - swsu_pkg::WIN_BASE;
      regs[i] = v;
      if (i == swsu_pkg::MASTER_IDX) begin
         if (!v[7]) begin
            for (int j = 0; j < 32; j++) regs[j] = 8'h00;
            ch_en[0] = 0;
            ch_en[1] = 0;
         end
         return;
      end
      if (!regs[swsu_pkg::MASTER_IDX][7]) return;
      if (i <= 4 || (i >= 6 && i <= 9)) begin
         c = (i <= 4) ? 0 : 1;
         k = i - (c ? 5 : 0);
         ctl_b[c*5+k] = v;
         if (k == 1) len_cnt[c] = 64 - (v & 8'h3F);
         if (k == 4 && v[7]) retrigger(c);
      end
   endfunction

   function automatic logic [7:0] bus_read(int addr);
      logic [7:0] b;
      if (addr < swsu_pkg::WIN_BASE || addr >= swsu_pkg::WIN_BASE + swsu_pkg::REGISTER_BYTES)
         return 8'hFF;
      if (addr - swsu_pkg::WIN_BASE != swsu_pkg::MASTER_IDX)
         return regs[addr - swsu_pkg::WIN_BASE];
      b = regs[swsu_pkg::MASTER_IDX] & 8'hF0;
      b[0] = ch_en[0];
      b[1] = ch_en[1];
      return b;
   endfunction

   function automatic logic signed [15:0] mixed_sample();
      int s;
      s = 0;
      for (int c = 0; c < 2; c++)
         if (ch_en[c] && level[c] > 0) s += level[c] * 2000 - 15000;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s[15:0];
   endfunction

   // work out the results of one accepted transaction
   function automatic void predict_sound(bus_item_type it);
      sound_result_type r;
      int cyc, cps, n, per;
      logic [7:0] pattern;
      r = '{rd: 8'h00, sv: 1'b0, smp: 16'sd0, last: 1'b1};
      if (it.mode != swsu_pkg::MODE_TICK) begin
         if (it.mode == swsu_pkg::MODE_READ) r.rd = bus_read(it.addr);
         else if (it.mode == swsu_pkg::MODE_WRITE) bus_write(it.addr, it.data);
         expected_sound.push_back(r);
         return;
      end
      cyc = (it.cyc > 32) ? 32 : it.cyc;
      frame_cnt += cyc;
      if (frame_cnt >= swsu_pkg::FRAME_DIVIDER) begin
         frame_cnt -= swsu_pkg::FRAME_DIVIDER;
         frame_step++;
         // length on even steps
         if (frame_step % 2 == 0)
            for (int c = 0; c < 2; c++)
               if (ctl_b[c*5+4][6] && len_cnt[c] > 0) begin
                  len_cnt[c]--;
                  if (len_cnt[c] == 0) ch_en[c] = 0;
               end
         // envelope on step 7
         if (frame_step == 7)
            for (int c = 0; c < 2; c++) begin
               per = ctl_b[c*5+2] & 7;
               if (ch_en[c] && per != 0 && env_cnt[c] > 0) begin
                  env_cnt[c]--;
                  if (env_cnt[c] == 0) begin
                     env_cnt[c] = per;
                     if (ctl_b[c*5+2][3]) begin
                        if (vol[c] < 15) vol[c]++;
                     end else if (vol[c] > 0) vol[c]--;
                  end
               end
            end
         if (frame_step >= 8) frame_step = 0;
      end
      // timers and duty
      for (int c = 0; c < 2; c++)
         if (ch_en[c]) begin
            ftimer[c] -= cyc;
            while (ftimer[c] <= 0) begin
               ftimer[c] += reload_period(c);
               duty_step[c] = (duty_step[c] + 1) & 7;
            end
            case (ctl_b[c*5+1][7:6])
               2'd0: pattern = 8'h01;
               2'd1: pattern = 8'h81;
               2'd2: pattern = 8'h87;
               default: pattern = 8'h7E;
            endcase
            level[c] = pattern[duty_step[c]] ? vol[c] : 0;
         end
      cps = (cps_reg < 2048) ? 2048 : cps_reg;
      phase_acc += cyc << 8;
      n = 0;
      while (phase_acc >= cps && n < 4) begin
         phase_acc -= cps;
         expected_sound.push_back('{rd: 8'h00, sv: 1'b1, smp: mixed_sample(), last: 1'b0});
         n++;
      end
      if (n == 0) expected_sound.push_back(r);
      else expected_sound[$].last = 1'b1;
   endfunction

   // sender: a new transaction only once the previous one has gone
   always @(negedge clock) begin
      if (!reset && n_taken == n_offered) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            offered = pending_items.pop_front();
            req_tdata <= {2'b00, offered.cyc, offered.data, offered.addr};
            req_tuser <= offered.mode;
            req_tvalid <= 1'b1;
            n_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req && !hold_done) begin
         hold_done = 1;
         hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // input transactions feed the predictor; results are checked in order
   always @(posedge clock) begin
      sound_result_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_sound(offered);
            n_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sound.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               e = expected_sound.pop_front();
               if (rsp_tdata[7:0] !== e.rd) begin
                  $error("read_data exp %h got %h", e.rd, rsp_tdata[7:0]);
                  errors++;
               end
               if (rsp_tuser !== e.sv) begin
                  $error("sample_valid exp %b got %b", e.sv, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[23:8] !== e.smp) begin
                  $error("sample_value exp %0d got %0d", e.smp,
                         $signed(rsp_tdata[23:8]));
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_result exp %b got %b", e.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic void add_item(logic [1:0] m, logic [15:0] a, logic [7:0] d,
                                    logic [5:0] c);
      pending_items.push_back('{mode: m, addr: a, data: d, cyc: c});
   endfunction

   // well-formed channel setup with random content, trigger set on the last write
   function automatic void add_channel_setup(int c);
      logic [15:0] b;
      b = (c == 0) ? 16'hFF10 : 16'hFF15;
      add_item(swsu_pkg::MODE_WRITE, b + 16'd1, 8'($urandom_range(255)), 6'd0);
      add_item(swsu_pkg::MODE_WRITE, b + 16'd2, 8'($urandom_range(255)), 6'd0);
      add_item(swsu_pkg::MODE_WRITE, b + 16'd3, 8'($urandom_range(255)), 6'd0);
      add_item(swsu_pkg::MODE_WRITE, b + 16'd4, 8'h80 | 8'($urandom_range(127)), 6'd0);
   endfunction

   function automatic void add_random(int count);
      int k;
      for (int j = 0; j < count; j++) begin
         k = $urandom_range(99);
         if (k < 8) begin
            add_item(swsu_pkg::MODE_WRITE, 16'hFF26, 8'h80 | 8'($urandom_range(127)), 6'd0);
            add_channel_setup($urandom_range(1));
            j += 4;
         end else if (k < 50)
            add_item(swsu_pkg::MODE_TICK, 16'($urandom), 8'($urandom),
                     6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(32)));
         else if (k < 72)
            add_item(swsu_pkg::MODE_WRITE,
                     ($urandom_range(9) == 0) ? 16'($urandom) :
                                                16'hFF10 + 16'($urandom_range(47)),
                     ($urandom_range(99) < 97) ? 8'h80 | 8'($urandom) : 8'($urandom),
                     6'($urandom));
         else if (k < 96)
            add_item(swsu_pkg::MODE_READ,
                     ($urandom_range(5) == 0) ? 16'($urandom) :
                                                16'hFF10 + 16'($urandom_range(47)),
                     8'($urandom), 6'($urandom));
         else if (k < 98)
            add_item(swsu_pkg::MODE_WRITE, 16'hFF26, 8'($urandom_range(127)), 6'd0);
         else
            add_item(MODE_NONE, 16'($urandom), 8'($urandom), 6'($urandom));
      end
   endfunction

   task automatic wait_quiet();
      while (pending_items.size() > 0 || n_taken != n_offered || expected_sound.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_sample_period(logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      cps_reg = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      for (int j = 0; j < swsu_pkg::REGISTER_BYTES; j++) regs[j] = 8'h00;
      for (int j = 0; j < 10; j++) ctl_b[j] = 8'h00;
      regs[swsu_pkg::MASTER_IDX] = 8'hF1;
      frame_cnt = 0; frame_step = 0; phase_acc = 0; cps_reg = swsu_pkg::CPS_RESET;
      for (int c = 0; c < 2; c++) begin
         ch_en[c] = 0; vol[c] = 0; env_cnt[c] = 0; ftimer[c] = 0;
         duty_step[c] = 0; len_cnt[c] = 0; level[c] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: window edges, master status, both channels, power-off
      add_item(swsu_pkg::MODE_READ, 16'hFF26, 8'h00, 6'd0);
      add_item(swsu_pkg::MODE_READ, 16'hFF10, 8'hFF, 6'h3F);
      add_item(swsu_pkg::MODE_READ, 16'h0000, 8'h00, 6'd0);
      add_item(swsu_pkg::MODE_READ, 16'hFFFF, 8'h00, 6'd0);
      add_item(swsu_pkg::MODE_READ, 16'hFF40, 8'h00, 6'd0);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF3F, 8'hA5, 6'd0);
      add_item(swsu_pkg::MODE_READ, 16'hFF3F, 8'h00, 6'd0);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF11, 8'hFF, 6'd0);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF12, 8'hF1, 6'd0);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF13, 8'hFF, 6'd0);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF14, 8'hC7, 6'd0);   // fastest period, length on
      add_item(swsu_pkg::MODE_WRITE, 16'hFF16, 8'h40, 6'd0);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF17, 8'h0F, 6'd0);   // rising envelope
      add_item(swsu_pkg::MODE_WRITE, 16'hFF18, 8'h00, 6'd0);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF19, 8'h80, 6'd0);
      add_item(swsu_pkg::MODE_TICK, 16'h0000, 8'h00, 6'd0);
      add_item(swsu_pkg::MODE_TICK, 16'hFFFF, 8'hFF, 6'd32);
      add_item(swsu_pkg::MODE_TICK, 16'h0000, 8'h00, 6'd63);  // clipped to 32
      add_item(swsu_pkg::MODE_READ, 16'hFF26, 8'h00, 6'd0);
      add_item(MODE_NONE, 16'hFFFF, 8'hFF, 6'h3F);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF26, 8'h00, 6'd0);     // power down
      add_item(swsu_pkg::MODE_WRITE, 16'hFF14, 8'h80, 6'd0);     // ignored while off
      add_item(swsu_pkg::MODE_READ, 16'hFF11, 8'h00, 6'd0);
      add_item(swsu_pkg::MODE_WRITE, 16'hFF26, 8'h80, 6'd0);
      wait_quiet();

      // no idling, with one long receiver hold-off
      set_sample_period(16'd2048);
      add_channel_setup(0);
      add_channel_setup(1);
      add_random(60);
      hold_req = 1;
      wait_quiet();

      set_sample_period(16'd65535);
      send_idle_pct = 71;
      add_channel_setup(0);
      add_random(55);
      wait_quiet();

      set_sample_period(16'd0);
      send_idle_pct = 0;
      recv_stall_pct = 71;
      add_channel_setup(1);
      add_random(55);
      wait_quiet();

      set_sample_period(16'($urandom_range(65535, 2048)));
      send_idle_pct = 6;
      recv_stall_pct = 6;
      add_channel_setup(0);
      add_random(55);
      wait_quiet();

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/swsu_pkg.sv
rtl/swsu_datapath.sv
rtl/swsu_control.sv
rtl/square_wave_sound_unit.sv
tb/tb_square_wave_sound_unit.sv
